@@ rtl/alarm_time_set_and_match_core_defines.svh @@
// ----------------------------------------------------------------------------
// Alarm time core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALARM_TIME_SET_AND_MATCH_CORE_DEFINES_SVH
`define ALARM_TIME_SET_AND_MATCH_CORE_DEFINES_SVH

// Same-cycle implication
`define ATSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ATSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/atsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsm_pkg
// Types, command codes and digit helpers for the alarm time core.
// ----------------------------------------------------------------------------
package atsm_pkg;

  // Command codes; code 7 is unused and leaves the state alone
  typedef enum logic [2:0] {
    CMD_RIGHT  = 3'd0,
    CMD_LEFT   = 3'd1,
    CMD_INC    = 3'd2,
    CMD_DEC    = 3'd3,
    CMD_LOAD   = 3'd4,
    CMD_COMMIT = 3'd5,
    CMD_TICK   = 3'd6
  } cmd_t;

  // Cursor positions
  localparam logic [2:0] PosHrTens = 3'd0;
  localparam logic [2:0] PosHrOnes = 3'd1;
  localparam logic [2:0] PosMnTens = 3'd2;
  localparam logic [2:0] PosMnOnes = 3'd3;
  localparam logic [2:0] PosScTens = 3'd4;
  localparam logic [2:0] PosScOnes = 3'd5;
  localparam logic [2:0] PosLast   = PosScOnes;

  // Largest value each digit takes before wrapping
  localparam logic [1:0] HrTensMax    = 2'd2;
  localparam logic [3:0] HrOnesMaxAt2 = 4'd3;
  localparam logic [2:0] TensMax      = 3'd5;
  localparam logic [3:0] OnesMax      = 4'd9;

  // One HH:MM:SS set of digits
  typedef struct packed {
    logic [1:0] hr_tens;
    logic [3:0] hr_ones;
    logic [2:0] mn_tens;
    logic [3:0] mn_ones;
    logic [2:0] sc_tens;
    logic [3:0] sc_ones;
  } digits_t;

  // Full editor state
  typedef struct packed {
    logic [2:0] cursor;
    digits_t    edit;
    digits_t    alarm;
  } state_t;

  function automatic logic [2:0] inc_tens(input logic [2:0] d);
    inc_tens = (d >= TensMax) ? 3'd0 : d + 3'd1;
  endfunction

  function automatic logic [3:0] inc_ones(input logic [3:0] d, input logic [3:0] max);
    inc_ones = (d >= max) ? 4'd0 : d + 4'd1;
  endfunction

  // tens*10 + ones for minutes and seconds
  function automatic logic [5:0] pair_val(input logic [2:0] t, input logic [3:0] o);
    pair_val = 6'(t) * 6'd10 + 6'(o);
  endfunction

endpackage

@@ rtl/atsm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsm_in_if / atsm_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface atsm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [4:0] now_hour;
  logic [5:0] now_minute;
  logic [5:0] now_second;

  modport source (output valid, command, now_hour, now_minute, now_second, input ready);
  modport sink   (input valid, command, now_hour, now_minute, now_second, output ready);
endinterface

interface atsm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] cursor;
  logic [1:0] edit_hour_tens;
  logic [3:0] edit_hour_ones;
  logic [2:0] edit_minute_tens;
  logic [3:0] edit_minute_ones;
  logic [2:0] edit_second_tens;
  logic [3:0] edit_second_ones;
  logic       edits_saved;
  logic       alarm_hit;

  modport source (output valid, cursor, edit_hour_tens, edit_hour_ones, edit_minute_tens,
                  edit_minute_ones, edit_second_tens, edit_second_ones, edits_saved,
                  alarm_hit, input ready);
  modport sink   (input valid, cursor, edit_hour_tens, edit_hour_ones, edit_minute_tens,
                  edit_minute_ones, edit_second_tens, edit_second_ones, edits_saved,
                  alarm_hit, output ready);
endinterface

@@ rtl/alarm_time_set_and_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_time_set_and_match_core
// HH:MM:SS alarm editor with cursor, digit edit, load/commit and time match.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Beat contents
//  ---------+-----+----------------------------------------------------------
//  in_ch    | in  | command, now_hour, now_minute, now_second
//  out_ch   | out | cursor, six edit digits, edits_saved, alarm_hit
//
//  One result beat per command beat; a beat passes the input register, then the
//  result register, one beat per cycle sustained while out_ch.ready holds.
//  The state update is a single pass of atsm_step between those two registers.
//  Reset (rst_n low, synchronous) clears cursor, edit and alarm digits.
//  A stalled result holds; the input register still takes one more beat.
// ----------------------------------------------------------------------------
`include "alarm_time_set_and_match_core_defines.svh"

module alarm_time_set_and_match_core import atsm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  atsm_in_if.sink     in_ch,
  atsm_out_if.source  out_ch
);

  logic       s1_vld_r;
  cmd_t       s1_cmd_r;
  logic [4:0] s1_hour_r;
  logic [5:0] s1_min_r;
  logic [5:0] s1_sec_r;

  state_t     state_r;
  state_t     state_nxt;
  logic       saved_nxt;
  logic       hit_nxt;

  logic       out_vld_r;
  digits_t    out_edit_r;
  logic [2:0] out_cursor_r;
  logic       out_saved_r;
  logic       out_hit_r;

  logic       adv;
  logic       in_rdy;

  // Handshake
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_rdy      = !s1_vld_r || adv;
  assign in_ch.ready = in_rdy;

  // Control and editor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '0;
    end else begin
      if (in_rdy) s1_vld_r <= in_ch.valid;
      if (adv) begin
        out_vld_r <= s1_vld_r;
        if (s1_vld_r) state_r <= state_nxt;
      end
    end
  end

  // Input beat register
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_rdy) begin
      s1_cmd_r  <= cmd_t'(in_ch.command);
      s1_hour_r <= in_ch.now_hour;
      s1_min_r  <= in_ch.now_minute;
      s1_sec_r  <= in_ch.now_second;
    end
  end

  atsm_step u_step (
    .st         (state_r),
    .cmd        (s1_cmd_r),
    .now_hour   (s1_hour_r),
    .now_minute (s1_min_r),
    .now_second (s1_sec_r),
    .st_nxt     (state_nxt),
    .saved      (saved_nxt),
    .hit        (hit_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      out_cursor_r <= state_nxt.cursor;
      out_edit_r   <= state_nxt.edit;
      out_saved_r  <= saved_nxt;
      out_hit_r    <= hit_nxt;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.cursor           = out_cursor_r;
  assign out_ch.edit_hour_tens   = out_edit_r.hr_tens;
  assign out_ch.edit_hour_ones   = out_edit_r.hr_ones;
  assign out_ch.edit_minute_tens = out_edit_r.mn_tens;
  assign out_ch.edit_minute_ones = out_edit_r.mn_ones;
  assign out_ch.edit_second_tens = out_edit_r.sc_tens;
  assign out_ch.edit_second_ones = out_edit_r.sc_ones;
  assign out_ch.edits_saved      = out_saved_r;
  assign out_ch.alarm_hit        = out_hit_r;

  // Checks
  `ATSM_ASSERT_NOW(a_cursor_range, 1'b1, state_r.cursor <= PosLast,
    "cursor left the digit range")
  `ATSM_ASSERT_NOW(a_hr_tens_range, 1'b1,
    state_r.edit.hr_tens <= HrTensMax && state_r.alarm.hr_tens <= HrTensMax,
    "hour tens digit out of range")
  `ATSM_ASSERT_NEXT(a_commit_saved, adv && s1_vld_r && s1_cmd_r == CMD_COMMIT,
    out_saved_r, "commit did not report edits saved")
  `ATSM_ASSERT_NEXT(a_hit_only_tick, adv && s1_vld_r && s1_cmd_r != CMD_TICK,
    !out_hit_r, "alarm hit on a non-tick beat")
  `ATSM_ASSERT_NOW(a_no_overrun, s1_vld_r && out_vld_r && !out_ch.ready,
    !in_rdy, "input accepted with both stages full")

endmodule

@@ rtl/atsm_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atsm_step
// Next-state and result logic for one command applied to the editor state.
// ----------------------------------------------------------------------------
module atsm_step import atsm_pkg::*; (
  input  state_t     st,
  input  cmd_t       cmd,
  input  logic [4:0] now_hour,
  input  logic [5:0] now_minute,
  input  logic [5:0] now_second,
  output state_t     st_nxt,
  output logic       saved,
  output logic       hit
);

  logic [2:0] pos;
  digits_t    e;
  digits_t    inc_d;
  digits_t    dec_d;
  logic [4:0] alarm_hour;

  assign pos = (st.cursor <= PosLast) ? st.cursor : PosHrTens;
  assign e   = st.edit;

  // Increment of the digit under the cursor
  always_comb begin
    inc_d = e;
    unique case (pos)
      PosHrTens: inc_d.hr_tens = (e.hr_tens >= HrTensMax) ? 2'd0 : e.hr_tens + 2'd1;
      PosHrOnes: begin
        // hour ones frozen when tens is out of range
        if (e.hr_tens == HrTensMax) begin
          inc_d.hr_ones = inc_ones(e.hr_ones, HrOnesMaxAt2);
        end else if (e.hr_tens < HrTensMax) begin
          inc_d.hr_ones = inc_ones(e.hr_ones, OnesMax);
        end
      end
      PosMnTens: inc_d.mn_tens = inc_tens(e.mn_tens);
      PosMnOnes: inc_d.mn_ones = inc_ones(e.mn_ones, OnesMax);
      PosScTens: inc_d.sc_tens = inc_tens(e.sc_tens);
      default:   inc_d.sc_ones = inc_ones(e.sc_ones, OnesMax);
    endcase
  end

  // Decrement, saturating at zero
  always_comb begin
    dec_d = e;
    unique case (pos)
      PosHrTens: if (e.hr_tens != 2'd0) dec_d.hr_tens = e.hr_tens - 2'd1;
      PosHrOnes: if (e.hr_ones != 4'd0) dec_d.hr_ones = e.hr_ones - 4'd1;
      PosMnTens: if (e.mn_tens != 3'd0) dec_d.mn_tens = e.mn_tens - 3'd1;
      PosMnOnes: if (e.mn_ones != 4'd0) dec_d.mn_ones = e.mn_ones - 4'd1;
      PosScTens: if (e.sc_tens != 3'd0) dec_d.sc_tens = e.sc_tens - 3'd1;
      default:   if (e.sc_ones != 4'd0) dec_d.sc_ones = e.sc_ones - 4'd1;
    endcase
  end

  // Committed hour may reach 29; compared as given
  assign alarm_hour = 5'(st.alarm.hr_tens) * 5'd10 + 5'(st.alarm.hr_ones);

  // Command decode
  always_comb begin
    st_nxt = st;
    hit    = 1'b0;
    unique case (cmd)
      CMD_RIGHT:  st_nxt.cursor = (pos >= PosLast) ? PosHrTens : pos + 3'd1;
      CMD_LEFT:   st_nxt.cursor = (pos == PosHrTens) ? PosLast : pos - 3'd1;
      CMD_INC:    st_nxt.edit = inc_d;
      CMD_DEC:    st_nxt.edit = dec_d;
      CMD_LOAD:   st_nxt.edit = st.alarm;
      CMD_COMMIT: st_nxt.alarm = st.edit;
      CMD_TICK:   hit = (alarm_hour == now_hour) &&
                        (pair_val(st.alarm.mn_tens, st.alarm.mn_ones) == now_minute) &&
                        (pair_val(st.alarm.sc_tens, st.alarm.sc_ones) == now_second);
      default: ;
    endcase
  end

  assign saved = (st_nxt.edit == st_nxt.alarm);

endmodule

@@ test/alarm_match_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_match_checker
// Watches the command and result channels of the alarm time core, keeps its
// own copy of cursor, edit digits and committed digits, and checks every
// result beat against the state predicted for the oldest open command.
// ----------------------------------------------------------------------------
module alarm_match_checker import atsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  atsm_in_if   in_ch,
  atsm_out_if  out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [2:0] cursor;
    digits_t    edit;
    logic       saved;
    logic       hit;
  } alarm_view_t;

  // Predicted editor state
  logic [2:0]  cur_pos;
  logic [3:0]  edit_d [6];
  logic [3:0]  alarm_d [6];

  alarm_view_t view_q [$];
  alarm_view_t seen;
  alarm_view_t want;
  int          beat_no;

  // Value at which a digit rolls back to zero on increment
  function automatic int rollover(input int pos);
    case (pos)
      PosHrTens: return 3;
      PosHrOnes: return (edit_d[PosHrTens] == 4'd2) ? 4 : 10;
      PosMnTens,
      PosScTens: return 6;
      default:   return 10;
    endcase
  endfunction

  function automatic int pair_of(input logic [3:0] t, input logic [3:0] o);
    return int'(t) * 10 + int'(o);
  endfunction

  // Apply one command to the predicted state, return the view it leaves
  function automatic alarm_view_t apply_command(input logic [2:0] cmd,
                                                input logic [4:0] hh,
                                                input logic [5:0] mm,
                                                input logic [5:0] ss);
    alarm_view_t r;
    logic        hit;
    logic        same;
    int          next;
    hit = 1'b0;
    case (cmd)
      CMD_RIGHT: cur_pos = (cur_pos == PosLast) ? PosHrTens : cur_pos + 3'd1;
      CMD_LEFT:  cur_pos = (cur_pos == PosHrTens) ? PosLast : cur_pos - 3'd1;
      CMD_INC: begin
        // hour ones is frozen when hour tens is out of range
        if (!(cur_pos == PosHrOnes && edit_d[PosHrTens] > 4'd2)) begin
          next = int'(edit_d[cur_pos]) + 1;
          if (next >= rollover(int'(cur_pos))) next = 0;
          edit_d[cur_pos] = 4'(next);
        end
      end
      CMD_DEC: begin
        if (edit_d[cur_pos] != 4'd0) edit_d[cur_pos] = edit_d[cur_pos] - 4'd1;
      end
      CMD_LOAD:   for (int i = 0; i < 6; i++) edit_d[i] = alarm_d[i];
      CMD_COMMIT: for (int i = 0; i < 6; i++) alarm_d[i] = edit_d[i];
      CMD_TICK: begin
        hit = (pair_of(alarm_d[0], alarm_d[1]) == int'(hh)) &&
              (pair_of(alarm_d[2], alarm_d[3]) == int'(mm)) &&
              (pair_of(alarm_d[4], alarm_d[5]) == int'(ss));
      end
      default: ;  // unused code leaves everything alone
    endcase
    same = 1'b1;
    for (int i = 0; i < 6; i++) if (edit_d[i] != alarm_d[i]) same = 1'b0;
    r.cursor        = cur_pos;
    r.edit.hr_tens  = edit_d[0][1:0];
    r.edit.hr_ones  = edit_d[1];
    r.edit.mn_tens  = edit_d[2][2:0];
    r.edit.mn_ones  = edit_d[3];
    r.edit.sc_tens  = edit_d[4][2:0];
    r.edit.sc_ones  = edit_d[5];
    r.saved         = same;
    r.hit           = hit;
    return r;
  endfunction

  function automatic string show(input alarm_view_t v);
    return $sformatf("cur %0d edit %0d%0d:%0d%0d:%0d%0d saved %0b hit %0b",
                     v.cursor, v.edit.hr_tens, v.edit.hr_ones, v.edit.mn_tens,
                     v.edit.mn_ones, v.edit.sc_tens, v.edit.sc_ones, v.saved, v.hit);
  endfunction

  // Track command beats and check result beats
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_pos = PosHrTens;
      for (int i = 0; i < 6; i++) begin
        edit_d[i]  = 4'd0;
        alarm_d[i] = 4'd0;
      end
      view_q.delete();
      beat_no = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        view_q.push_back(apply_command(in_ch.command, in_ch.now_hour,
                                       in_ch.now_minute, in_ch.now_second));
      if (out_ch.valid && out_ch.ready) begin
        seen.cursor       = out_ch.cursor;
        seen.edit.hr_tens = out_ch.edit_hour_tens;
        seen.edit.hr_ones = out_ch.edit_hour_ones;
        seen.edit.mn_tens = out_ch.edit_minute_tens;
        seen.edit.mn_ones = out_ch.edit_minute_ones;
        seen.edit.sc_tens = out_ch.edit_second_tens;
        seen.edit.sc_ones = out_ch.edit_second_ones;
        seen.saved        = out_ch.edits_saved;
        seen.hit          = out_ch.alarm_hit;
        if (view_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: result beat %0d with no command open: %s", beat_no, show(seen));
        end else begin
          want = view_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: result beat %0d\n  expected %s\n  actual   %s",
                       beat_no, show(want), show(seen));
          end
        end
        beat_no++;
      end
    end
    pending = view_q.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into the alarm time core: a directed walk over cursor
// wrap, digit rollover, decrement floor, commit/load and matching ticks, then
// random edit bursts, commits, loads, exact, near and random ticks under four
// idle/stall mixes. The checker beside the block scores every result beat.
// ----------------------------------------------------------------------------
module testbench import atsm_pkg::*; ();

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int         PHASE_BEATS = 256;

  logic    clk;
  logic    rst_n;
  int      fail_count;
  int      pending;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      beats_sent = 0;
  digits_t known_alarm = '0;

  atsm_in_if  in_ch ();
  atsm_out_if out_ch ();

  alarm_time_set_and_match_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alarm_match_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result-side backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Any result with edits saved shows the committed alarm time
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.edits_saved) begin
      known_alarm <= {out_ch.edit_hour_tens, out_ch.edit_hour_ones, out_ch.edit_minute_tens,
                      out_ch.edit_minute_ones, out_ch.edit_second_tens,
                      out_ch.edit_second_ones};
    end
  end

  // One command beat, with random sender gaps ahead of it
  task automatic send_beat(input logic [2:0] cmd, input logic [4:0] hh,
                           input logic [5:0] mm, input logic [5:0] ss);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.now_hour   <= hh;
    in_ch.now_minute <= mm;
    in_ch.now_second <= ss;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Time fields are ignored outside a tick, so let them roam
  task automatic send_cmd(input logic [2:0] cmd);
    send_beat(cmd, 5'($urandom_range(31)), 6'($urandom_range(63)), 6'($urandom_range(63)));
  endtask

  // Hold the sender off until every open command has its result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Tick at the committed time, one field off by one, or anywhere
  task automatic send_tick();
    int         mode;
    int         which;
    logic [4:0] hh;
    logic [5:0] mm;
    logic [5:0] ss;
    mode = $urandom_range(99);
    if (mode < 20) drain_results();
    hh = 5'(int'(known_alarm.hr_tens) * 10 + int'(known_alarm.hr_ones));
    mm = 6'(int'(known_alarm.mn_tens) * 10 + int'(known_alarm.mn_ones));
    ss = 6'(int'(known_alarm.sc_tens) * 10 + int'(known_alarm.sc_ones));
    if (mode >= 75) begin
      hh = 5'($urandom_range(31));
      mm = 6'($urandom_range(63));
      ss = 6'($urandom_range(63));
    end else if (mode >= 55) begin
      which = $urandom_range(2);
      case (which)
        0:       hh = $urandom_range(1) ? hh + 5'd1 : hh - 5'd1;
        1:       mm = $urandom_range(1) ? mm + 6'd1 : mm - 6'd1;
        default: ss = $urandom_range(1) ? ss + 6'd1 : ss - 6'd1;
      endcase
    end
    send_beat(CMD_TICK, hh, mm, ss);
  endtask

  // Mostly edit sessions with commits and ticks, some raw noise
  task automatic random_phase(input int count);
    int first;
    int pick;
    int len;
    first = beats_sent;
    while (beats_sent - first < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(12, 3);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 45)      send_cmd(CMD_INC);
          else if (pick < 60) send_cmd(CMD_DEC);
          else if (pick < 80) send_cmd(CMD_RIGHT);
          else                send_cmd(CMD_LEFT);
        end
      end else if (pick < 55) begin
        send_cmd(CMD_COMMIT);
      end else if (pick < 62) begin
        send_cmd(CMD_LOAD);
      end else if (pick < 85) begin
        send_tick();
      end else begin
        len = $urandom_range(3, 1);
        repeat (len) send_cmd(3'($urandom_range(7)));
      end
    end
  endtask

  // Stimulus
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_RIGHT;
    in_ch.now_hour   = '0;
    in_ch.now_minute = '0;
    in_ch.now_second = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk
    send_beat(CMD_TICK, 5'd0, 6'd0, 6'd0);        // alarm out of reset is 00:00:00
    send_beat(CMD_UNUSED, 5'd31, 6'd63, 6'd63);
    send_cmd(CMD_DEC);                            // floor at zero
    send_cmd(CMD_LEFT);                           // cursor wraps to second ones
    send_cmd(CMD_DEC);
    send_cmd(CMD_RIGHT);                          // and back to hour tens
    repeat (3) send_cmd(CMD_INC);                 // hour tens 1, 2, back to 0
    send_cmd(CMD_INC);
    send_cmd(CMD_RIGHT);
    repeat (9) send_cmd(CMD_INC);                 // hour ones up to 9
    send_cmd(CMD_LEFT);
    send_cmd(CMD_INC);                            // tens 2 with ones still 9
    send_cmd(CMD_RIGHT);
    send_cmd(CMD_INC);                            // 9 under tens 2 rolls to 0
    send_cmd(CMD_COMMIT);
    send_beat(CMD_TICK, 5'd20, 6'd0, 6'd0);
    send_cmd(CMD_INC);
    send_cmd(CMD_LOAD);

    // Random part: no idling, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      random_phase(PHASE_BEATS);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS alarm_time_set_and_match_core");
    end else begin
      $display("FAIL alarm_time_set_and_match_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAIL alarm_time_set_and_match_core");
    $finish;
  end

endmodule
